@@ src/bfa_pkg.sv @@
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int FCOUNT_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int FRAME_SHIFT = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int FIDX_W      = 16;
    localparam int WIDX_W      = FIDX_W - BIT_W + 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_OFFSET = 1'd1;

    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 16'd32768;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

endpackage

@@ src/bitmap_frame_allocator_top.sv @@
// Bitmap frame allocator: top level with the bitmap memory and its sequencer.
// A command is decoded, then each bitmap word it visits is read (RD) and modified and
// written (WR), then its result word is issued. Allocate scans at most ceil(limit/32)
// words, a mark or free spans its region; with no word to visit, decode goes straight to
// the result. One command at a time; an untaken result word holds the next one back.
// Reset: synchronous; then a clearing pass writes all ones to all MAP_WORDS words
// (1024 by default) with s_ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module bitmap_frame_allocator_top #(
    parameter int unsigned MAX_FRAMES = 32768
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bfa_pkg::CMD_W-1:0]         s_cmd,
    input  logic [bfa_pkg::ADDR_W-1:0]        s_address,
    input  logic [bfa_pkg::ADDR_W-1:0]        s_region_size,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bfa_pkg::ADDR_W-1:0]        m_result_address,
    output logic                              m_ok,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfa_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_FRAMES + 31) / 32;
    localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

    state_t               state_reg, state_next;
    logic [WW-1:0]        clr_reg, clr_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    logic [FIDX_W-1:0]    first_reg, first_next;
    logic [FIDX_W-1:0]    last_reg, last_next;
    logic                 alloc_reg, alloc_next;
    logic                 used_reg, used_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]    m_addr_reg, m_addr_next;
    logic                 m_ok_reg, m_ok_next;
    logic [FCOUNT_W-1:0]  fc_reg;
    logic [ADDR_W-1:0]    voff_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [WW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WW-1:0]        mem_raddr;

    logic [FCOUNT_W-1:0]  lim;

    // Region and free decode.
    logic [19:0]          reg_first;
    logic [20:0]          reg_count;
    logic [21:0]          reg_end;
    logic [FIDX_W-1:0]    reg_endc;
    logic                 reg_empty;
    logic [ADDR_W-1:0]    free_diff;
    logic [19:0]          free_idx;
    logic                 free_hit;

    // Allocation search within one word.
    logic [16:0]          alloc_base;
    logic [16:0]          alloc_rem;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] cand;
    logic [BIT_W-1:0]     cand_pos;
    logic [WIDX_W-1:0]    w_inc;
    logic [FIDX_W-1:0]    alloc_idx;

    // Region mask within one word.
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] reg_mask;
    logic                 at_last_word;

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_result_address = m_addr_reg;
    assign m_ok             = m_ok_reg;

    // Frame counts above the compiled capacity act as the capacity.
    assign lim = (32'(fc_reg) < MAX_FRAMES) ? fc_reg : FCOUNT_W'(MAX_FRAMES);

    assign reg_first = addr_reg[ADDR_W-1:FRAME_SHIFT];
    assign reg_count = {1'b0, size_reg[ADDR_W-1:FRAME_SHIFT]} + 21'(|size_reg[FRAME_SHIFT-1:0]);
    assign reg_end   = {2'b00, reg_first} + {1'b0, reg_count};
    assign reg_endc  = (reg_end < 22'(lim)) ? reg_end[FIDX_W-1:0] : lim;
    assign reg_empty = ({2'b00, reg_first} >= 22'(reg_endc));

    assign free_diff = addr_reg - voff_reg;
    assign free_idx  = free_diff[ADDR_W-1:FRAME_SHIFT];
    assign free_hit  = (addr_reg != '0) && (free_idx < 20'(lim));

    assign alloc_base = {w_reg, {BIT_W{1'b0}}};
    assign alloc_rem  = 17'(lim) - alloc_base;
    assign w_inc      = w_reg + WIDX_W'(1);

    always_comb begin
        if (alloc_rem >= 17'(WORD_BITS)) begin
            range_mask = '1;
        end else begin
            range_mask = ~({WORD_BITS{1'b1}} << alloc_rem[BIT_W-1:0]);
        end
        // Frame zero is never handed out.
        if (w_reg == '0) begin
            range_mask[0] = 1'b0;
        end
    end

    assign cand = ~rd_data_reg & range_mask;

    always_comb begin
        cand_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                cand_pos = BIT_W'(j);
            end
        end
    end

    assign alloc_idx = {w_reg[WIDX_W-2:0], cand_pos};

    assign lo_bit       = (w_reg[WIDX_W-2:0] == first_reg[FIDX_W-1:BIT_W]) ?
                          first_reg[BIT_W-1:0] : '0;
    assign at_last_word = (w_reg == {1'b0, last_reg[FIDX_W-1:BIT_W]});
    assign hi_bit       = at_last_word ? last_reg[BIT_W-1:0] : '1;
    assign reg_mask     = ({WORD_BITS{1'b1}} << lo_bit) &
                          ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));

    assign mem_raddr = WW'(w_reg);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        w_next        = w_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        alloc_next    = alloc_reg;
        used_next     = used_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_ok_next     = m_ok_reg;
        mem_we        = 1'b0;
        mem_waddr     = WW'(w_reg);
        mem_wdata     = rd_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '1;
                if (32'(clr_reg) == MAP_WORDS - 1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + WW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    addr_next  = s_address;
                    size_next  = s_region_size;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                res_addr_next = '0;
                res_ok_next   = 1'b0;
                alloc_next    = 1'b0;
                used_next     = 1'b0;
                state_next    = ST_DONE;
                case (cmd_reg) inside
                    CMD_ALLOC: begin
                        alloc_next = 1'b1;
                        w_next     = '0;
                        if (lim != '0) begin
                            state_next = ST_RD;
                        end
                    end
                    CMD_FREE: begin
                        // A free is a one-frame region cleared.
                        if (free_hit) begin
                            first_next = free_idx[FIDX_W-1:0];
                            last_next  = free_idx[FIDX_W-1:0];
                            w_next     = {1'b0, free_idx[FIDX_W-1:BIT_W]};
                            state_next = ST_RD;
                        end
                    end
                    CMD_MARK_USED, CMD_MARK_FREE: begin
                        used_next = (cmd_reg == CMD_MARK_USED);
                        if (!reg_empty) begin
                            first_next = reg_first[FIDX_W-1:0];
                            last_next  = reg_endc - FIDX_W'(1);
                            w_next     = {1'b0, reg_first[FIDX_W-1:BIT_W]};
                            state_next = ST_RD;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                if (alloc_reg) begin
                    if (cand != '0) begin
                        mem_we        = 1'b1;
                        mem_wdata     = rd_data_reg | (WORD_BITS'(1) << cand_pos);
                        res_addr_next = 32'({alloc_idx, {FRAME_SHIFT{1'b0}}}) + voff_reg;
                        res_ok_next   = 1'b1;
                        state_next    = ST_DONE;
                    end else if ({w_inc, {BIT_W{1'b0}}} >= 17'(lim)) begin
                        state_next = ST_DONE;
                    end else begin
                        w_next     = w_inc;
                        state_next = ST_RD;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = used_reg ? (rd_data_reg | reg_mask) : (rd_data_reg & ~reg_mask);
                    if (at_last_word) begin
                        res_ok_next = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        w_next     = w_inc;
                        state_next = ST_RD;
                    end
                end
            end
            ST_DONE: begin
                // Wait here while the output register still holds an untaken word.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_ok_next    = res_ok_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            fc_reg      <= FRAME_COUNT_RST;
            voff_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT:    fc_reg   <= cfg_data[FCOUNT_W-1:0];
                    CFG_VIRTUAL_OFFSET: voff_reg <= cfg_data;
                    default:            fc_reg   <= fc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        alloc_reg    <= alloc_next;
        used_reg     <= used_next;
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        m_addr_reg   <= m_addr_next;
        m_ok_reg     <= m_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[mem_raddr];
    end

endmodule

@@ src/bfa_checker.sv @@
// Port-level checks for the bitmap frame allocator and their bind to the top level.
`timescale 1ns / 1ps

module bfa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [bfa_pkg::ADDR_W-1:0]        m_result_address,
    input logic                              m_ok
);
    import bfa_pkg::*;

    // A result word that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_address) && $stable(m_ok))
        else $error("result word changed while stalled");

    // A word without effect carries a zero address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_result_address == '0)
        else $error("failed result with nonzero address");

    // Once a command is taken, s_ready stays low through CALC and the state that follows it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too soon");

    // A new result word only appears after a busy cycle.
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word appeared while idle");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_address (m_result_address),
    .m_ok             (m_ok)
);
